/* hdl/khtbl_pkg.sv */
`timescale 1ns / 1ps

package khtbl_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    OP_ADD        = 2'd0,
    OP_DEL_KEY    = 2'd1,
    OP_DEL_HANDLE = 2'd2,
    OP_LOOKUP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_MISS   = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    op_t         operation;
    logic [31:0] entry_id;
    logic [31:0] relay_address;
    logic [15:0] timer_handle;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  slot_index;
    logic [15:0] result_handle;
    logic        handle_released;
  } res_t;

  typedef struct packed {
    logic [31:0] id;
    logic [30:0] relay;
    logic [15:0] handle;
  } slot_t;

  typedef struct packed {
    logic  en;
    idx_t  addr;
    slot_t data;
  } mem_wr_t;

  function automatic logic [3:0] to_index4(input idx_t idx);
    logic [IDX_W+3:0] ext;
    ext = {4'b0000, idx};
    return ext[3:0];
  endfunction

endpackage

/* hdl/khtbl_mem.sv */
`timescale 1ns / 1ps

module khtbl_mem (
  input  logic             clk,
  input  khtbl_pkg::mem_wr_t wr,
  input  logic             rd_en,
  input  khtbl_pkg::idx_t  rd_addr,
  output khtbl_pkg::slot_t rd_data
);
  import khtbl_pkg::*;

  slot_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/khtbl_ctrl.sv */
`timescale 1ns / 1ps

module khtbl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  khtbl_pkg::req_t    req_in,
  output logic               res_load,
  output khtbl_pkg::res_t    res,
  input  logic               res_space,
  output khtbl_pkg::mem_wr_t mem_wr,
  output logic               rd_en,
  output khtbl_pkg::idx_t    rd_addr,
  input  khtbl_pkg::slot_t   rd_data
);
  import khtbl_pkg::*;

  state_t           state, state_next;
  logic [SLOTS-1:0] valid;
  req_t             req;
  logic [CNT_W-1:0] rcnt;
  logic             chk_vld;
  idx_t             chk_idx;
  logic             hit;
  idx_t             hit_idx;
  logic [15:0]      hit_handle;
  logic             free_found;
  idx_t             free_idx;

  logic accept;
  logic more;
  logic match;
  logic chk_last;
  logic negative;
  logic fire;
  logic valid_wr;
  logic valid_val;
  idx_t valid_idx;

  assign accept   = req_valid && req_ready;
  assign more     = rcnt < CNT_W'(SLOTS);
  assign chk_last = chk_idx == IDX_W'(SLOTS - 1);
  assign negative = req.operation == OP_ADD && req.relay_address[31];
  assign fire     = state == S_FINISH && res_space;

  always_comb begin
    if (req.operation == OP_DEL_HANDLE) begin
      match = valid[chk_idx] && rd_data.handle == req.timer_handle;
    end else begin
      match = valid[chk_idx] && rd_data.id == req.entry_id &&
              {1'b0, rd_data.relay} == req.relay_address;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req_in.operation == OP_ADD && req_in.relay_address[31]) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (chk_vld && (match || chk_last)) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (res_space) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_ready          = state == S_IDLE;
    rd_en              = state == S_SCAN && more;
    rd_addr            = rcnt[IDX_W-1:0];
    res_load           = fire;
    res.status         = ST_MISS;
    res.slot_index     = 4'd0;
    res.result_handle  = 16'd0;
    res.handle_released = 1'b0;
    mem_wr.en          = 1'b0;
    mem_wr.addr        = hit_idx;
    mem_wr.data.id     = req.entry_id;
    mem_wr.data.relay  = req.relay_address[30:0];
    mem_wr.data.handle = req.timer_handle;
    valid_wr           = 1'b0;
    valid_val          = 1'b0;
    valid_idx          = hit_idx;
    case (req.operation)
      OP_ADD: begin
        if (negative) begin
          res.status = ST_REJECT;
        end else if (hit) begin
          res.status     = ST_DONE;
          res.slot_index = to_index4(hit_idx);
          mem_wr.en      = fire;
          valid_wr       = fire;
          valid_val      = 1'b1;
          if (hit_handle != req.timer_handle) begin
            res.result_handle   = hit_handle;
            res.handle_released = 1'b1;
          end
        end else if (free_found) begin
          res.status     = ST_DONE;
          res.slot_index = to_index4(free_idx);
          mem_wr.en      = fire;
          mem_wr.addr    = free_idx;
          valid_wr       = fire;
          valid_val      = 1'b1;
          valid_idx      = free_idx;
        end
      end
      OP_DEL_KEY, OP_DEL_HANDLE: begin
        if (hit) begin
          res.status          = ST_DONE;
          res.slot_index      = to_index4(hit_idx);
          res.result_handle   = hit_handle;
          res.handle_released = 1'b1;
          valid_wr            = fire;
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          res.status        = ST_DONE;
          res.slot_index    = to_index4(hit_idx);
          res.result_handle = hit_handle;
        end
      end
      default: res.status = ST_MISS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      valid   <= '0;
      chk_vld <= 1'b0;
    end else begin
      state <= state_next;
      if (valid_wr) begin
        valid[valid_idx] <= valid_val;
      end
      if (accept) begin
        chk_vld <= 1'b0;
      end else if (state == S_SCAN) begin
        chk_vld <= more;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req        <= req_in;
      rcnt       <= '0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (state == S_SCAN) begin
      if (more) begin
        rcnt <= rcnt + CNT_W'(1);
      end
      chk_idx <= rcnt[IDX_W-1:0];
      if (chk_vld) begin
        if (match) begin
          hit        <= 1'b1;
          hit_idx    <= chk_idx;
          hit_handle <= rd_data.handle;
        end
        if (!valid[chk_idx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= chk_idx;
        end
      end
    end
  end

endmodule

/* hdl/keyed_handle_table.sv */
`timescale 1ns / 1ps
// keyed_handle_table: associative table of timer handles keyed by (entry_id, relay_address)
//
// input channel s_*: one transaction per request. s_tuser carries the operation
// (add, delete by key, delete by handle, lookup), s_tdata the key and the handle.
// output channel m_*: exactly one result transaction per request, in order.
//
// each request walks the slot memory from slot 0 upward, one read per cycle,
// stopping at the first matching valid slot; the memory read is registered. an add
// with a negative relay address skips the walk and goes from idle straight to the
// finish state; any other request goes idle, scan, finish. an add without a match
// always scans every slot. finish loads the result once the output register is free.
// one request is in flight at a time; s_tready is high only while idle, so with an
// open output the next request is accepted in the cycle after the result is loaded.
//
// the result sits in an output register; when m_tready is low the block still takes
// one more request, finishes it and holds that result, with s_tready low, until the
// output register is taken.
// reset clears every valid mark and drops any result not yet delivered; slot
// contents are only used under a set valid mark, so the memory is not cleared.
module keyed_handle_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // entry_id[31:0], relay_address[63:32], timer_handle[79:64]
  input  logic [1:0]  s_tuser,   // operation[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // status[1:0], slot_index[5:2], result_handle[21:6],
                                 // handle_released[22], zero[23]
);
  import khtbl_pkg::*;

  req_t    req_in;
  res_t    res;
  res_t    out;
  logic    res_load;
  logic    res_space;
  mem_wr_t mem_wr;
  logic    rd_en;
  idx_t    rd_addr;
  slot_t   rd_data;

  assign req_in.operation     = op_t'(s_tuser);
  assign req_in.entry_id      = s_tdata[31:0];
  assign req_in.relay_address = s_tdata[63:32];
  assign req_in.timer_handle  = s_tdata[79:64];

  assign res_space = !m_tvalid || m_tready;

  khtbl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req_in    (req_in),
    .res_load  (res_load),
    .res       (res),
    .res_space (res_space),
    .mem_wr    (mem_wr),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  khtbl_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out <= res;
    end
  end

  assign m_tdata = {1'b0, out.handle_released, out.result_handle, out.slot_index,
                    out.status};

endmodule
